// ===== src/rfdc_pkg.sv =====
// Shared types, codes and helpers for the rx frame deframer/checker.
// No dependencies; imported by rfdc_step and rx_frame_deframer_checker.
package rfdc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW    = 1;
  localparam logic [CfgIdxW-1:0] CFG_HEADER = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOOTER = 1'd1;

  localparam logic [7:0] HEADER_RST = 8'h55;
  localparam logic [7:0] FOOTER_RST = 8'hAA;

  // Frame layout
  localparam logic [7:0] OFS_DEST   = 8'd3;
  localparam logic [7:0] OFS_SRC    = 8'd4;
  localparam logic [7:0] OFS_OPCODE = 8'd5;
  localparam logic [7:0] OFS_CMD_HI = 8'd6;
  localparam logic [7:0] OFS_CMD_LO = 8'd7;
  localparam logic [7:0] OFS_PAYLD  = 8'd8;
  localparam logic [7:0] MIN_LEN    = 8'd3;
  localparam logic [7:0] FULL_LEN   = 8'd10;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_COMP = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_FOOTER  = 2'd2,
    ST_CHKSUM  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FT_REQUEST = 2'd0,
    FT_NOTIFY  = 2'd1,
    FT_RESP    = 2'd2,
    FT_UNKNOWN = 2'd3
  } ftype_e;

  localparam logic [7:0] OP_REQUEST = 8'h01;
  localparam logic [7:0] OP_NOTIFY  = 8'h02;
  localparam logic [7:0] OP_RESP    = 8'h04;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [7:0]  running_xor;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [7:0]  opcode;
    logic [15:0] command;
    logic [7:0]  checksum;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic [7:0]  opcode;
    ftype_e      frame_type;
    logic [15:0] command;
    logic [7:0]  payload_len;
    status_e     status;
  } result_t;

  function automatic ftype_e type_of(input logic [7:0] op);
    ftype_e t;
    priority case (op)
      OP_REQUEST: t = FT_REQUEST;
      OP_NOTIFY:  t = FT_NOTIFY;
      OP_RESP:    t = FT_RESP;
      default:    t = FT_UNKNOWN;
    endcase
    return t;
  endfunction

  // Result with every field at its idle value
  function automatic result_t blank_result(input kind_e k);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.frame_type = FT_UNKNOWN;
    return r;
  endfunction

endpackage

// ===== src/rfdc_step.sv =====
// Per-byte next-state and result logic of the deframer (pure combinational).
// Depends on rfdc_pkg.
module rfdc_step (
  input  rfdc_pkg::state_t  cur_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        header_i,
  input  logic [7:0]        footer_i,
  output rfdc_pkg::state_t  nxt_o,
  output logic              res_valid_o,
  output rfdc_pkg::result_t res_o
);
  import rfdc_pkg::*;

  logic [7:0] ofs;
  logic [7:0] len;
  logic [8:0] ofs_p1;
  logic [8:0] ofs_p2;
  logic       len_bad;
  logic       last;
  state_t     cleared;

  assign ofs     = cur_i.byte_index;
  assign len     = cur_i.frame_length;
  assign ofs_p1  = {1'b0, ofs} + 9'd1;
  assign ofs_p2  = {1'b0, ofs} + 9'd2;
  assign len_bad = (rx_byte_i != ~len) || (len < MIN_LEN);
  assign last    = ofs_p1 >= {1'b0, len};

  always_comb begin
    cleared             = cur_i;
    cleared.running_xor = '0;
    cleared.dest        = '0;
    cleared.src         = '0;
    cleared.opcode      = '0;
    cleared.command     = '0;
    cleared.checksum    = '0;
  end

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = blank_result(KIND_PAYLOAD);
    unique case (cur_i.phase)
      PH_HUNT: begin
        if (rx_byte_i == header_i) begin
          nxt_o            = cleared;
          nxt_o.phase      = PH_LEN;
          nxt_o.byte_index = 8'd1;
        end
      end
      PH_LEN: begin
        nxt_o.frame_length = rx_byte_i;
        nxt_o.phase        = PH_COMP;
        nxt_o.byte_index   = 8'd2;
      end
      PH_COMP: begin
        if (len_bad) begin
          res_valid_o = 1'b1;
          res_o       = blank_result(KIND_LEN_ERR);
          nxt_o       = cleared;
          // rescan: length byte first, then complement byte
          priority if (len == header_i) begin
            nxt_o.frame_length = rx_byte_i;
            nxt_o.phase        = PH_COMP;
            nxt_o.byte_index   = 8'd2;
          end else if (rx_byte_i == header_i) begin
            nxt_o.phase      = PH_LEN;
            nxt_o.byte_index = 8'd1;
          end else begin
            nxt_o.phase      = PH_HUNT;
            nxt_o.byte_index = 8'd0;
          end
        end else if (len == MIN_LEN) begin
          res_valid_o      = 1'b1;
          res_o            = blank_result(KIND_REPORT);
          res_o.status     = ST_SHORT;
          nxt_o.phase      = PH_HUNT;
          nxt_o.byte_index = 8'd0;
        end else begin
          nxt_o.phase      = PH_BODY;
          nxt_o.byte_index = 8'd3;
        end
      end
      PH_BODY: begin
        if (ofs == OFS_DEST)   nxt_o.dest           = rx_byte_i;
        if (ofs == OFS_SRC)    nxt_o.src            = rx_byte_i;
        if (ofs == OFS_OPCODE) nxt_o.opcode         = rx_byte_i;
        if (ofs == OFS_CMD_HI) nxt_o.command[15:8]  = rx_byte_i;
        if (ofs == OFS_CMD_LO) nxt_o.command[7:0]   = rx_byte_i;
        if (last) begin
          nxt_o.phase      = PH_HUNT;
          nxt_o.byte_index = 8'd0;
          res_valid_o      = 1'b1;
          res_o            = blank_result(KIND_REPORT);
          if (len < FULL_LEN) begin
            res_o.status = ST_SHORT;
          end else begin
            res_o.dest_addr   = nxt_o.dest;
            res_o.src_addr    = nxt_o.src;
            res_o.opcode      = nxt_o.opcode;
            res_o.frame_type  = type_of(nxt_o.opcode);
            res_o.command     = nxt_o.command;
            res_o.payload_len = len - FULL_LEN;
            priority if (rx_byte_i != footer_i) begin
              res_o.status = ST_FOOTER;
            end else if (cur_i.running_xor != cur_i.checksum) begin
              res_o.status = ST_CHKSUM;
            end else begin
              res_o.status = ST_OK;
            end
          end
        end else begin
          nxt_o.byte_index = ofs_p1[7:0];
          if (ofs_p2 == {1'b0, len}) begin
            nxt_o.checksum = rx_byte_i;
          end else begin
            nxt_o.running_xor = cur_i.running_xor ^ rx_byte_i;
            if (ofs >= OFS_PAYLD) begin
              res_valid_o     = 1'b1;
              res_o           = blank_result(KIND_PAYLOAD);
              res_o.data_byte = rx_byte_i;
            end
          end
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== src/rx_frame_deframer_checker.sv =====
// Length-prefixed frame deframer with XOR checksum and footer check.
// Each result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle; the only hold-off is a full, stalled output register.
// Reset (rst_ni low, async): hunting for header, all counters and holds zero,
// header 0x55, footer 0xAA, output register empty.
// Depends on rfdc_pkg and rfdc_step.
module rx_frame_deframer_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  data_byte_o,
  output logic [7:0]                  dest_addr_o,
  output logic [7:0]                  src_addr_o,
  output logic [7:0]                  opcode_o,
  output logic [1:0]                  frame_type_o,
  output logic [15:0]                 command_o,
  output logic [7:0]                  payload_len_o,
  output logic [1:0]                  status_o,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [rfdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import rfdc_pkg::*;

  logic [7:0] header_q;
  logic [7:0] footer_q;
  state_t     state_q;
  state_t     state_d;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;
  logic       in_take;

  // A request is taken whenever the output register can absorb its result:
  // either it is empty or it is being drained this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers; header/footer take effect on the next byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RST;
      footer_q <= FOOTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER: header_q <= cfg_data_i;
        CFG_FOOTER: footer_q <= cfg_data_i;
        default:    header_q <= header_q;
      endcase
    end
  end

  rfdc_step u_step (
    .cur_i       (state_q),
    .rx_byte_i   (rx_byte_i),
    .header_i    (header_q),
    .footer_i    (footer_q),
    .nxt_o       (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Frame tracking state: phase, offset, length and field holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  // Output register: loads on every accepted request; a byte without a
  // result just lets a drained entry go empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign data_byte_o   = out_q.data_byte;
  assign dest_addr_o   = out_q.dest_addr;
  assign src_addr_o    = out_q.src_addr;
  assign opcode_o      = out_q.opcode;
  assign frame_type_o  = out_q.frame_type;
  assign command_o     = out_q.command;
  assign payload_len_o = out_q.payload_len;
  assign status_o      = out_q.status;

endmodule
